### rtl/asp_pkg.sv
`default_nettype none

package asp_pkg;

    // Item field widths
    localparam int OPCODE_W = 3;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int INC_W    = 18;

    // Decoder state widths
    localparam int POS_W   = 17;
    localparam int PHASE_W = 19;
    localparam int PRED_W  = 12;
    localparam int IDX_W   = 6;
    localparam int STEP_W  = 11;
    localparam int DIFF_W  = 12;

    // Sample memory
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [INC_W-1:0] DEFAULT_INC = INC_W'(23219);
    localparam logic [IDX_W-1:0] IDX_MAX     = IDX_W'(48);
    localparam logic [PRED_W-1:0] PRED_HI    = 12'h7FF;
    localparam logic [PRED_W-1:0] PRED_LO    = 12'h800;

    // Sequencer program counter
    localparam int UPC_W = 5;

    // Item kinds carried on tuser
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CTRL   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_NIBBLE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_START  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd4;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_LOAD      = 4'd1,
        DP_CTRL      = 4'd2,
        DP_DIFF_DATA = 4'd3,
        DP_DIFF_MEM  = 4'd4,
        DP_APPLY     = 4'd5,
        DP_START     = 4'd6,
        DP_PHASE_ADD = 4'd7,
        DP_PHASE_SUB = 4'd8,
        DP_MEM_READ  = 4'd9,
        DP_STOP      = 4'd10,
        DP_EMIT_ACT  = 4'd11,
        DP_EMIT_IDLE = 4'd12
    } t_dpop;

    // Branch conditions
    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_DISPATCH  = 3'd2,
        C_NO_GO     = 3'd3,
        C_PHASE_LOW = 3'd4,
        C_AT_END    = 3'd5,
        C_OUT_FREE  = 3'd6
    } t_cond;

    typedef struct packed {
        t_dpop             op;
        t_cond             cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic  accept;
        t_dpop op;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic no_go;
        logic phase_low;
        logic at_end;
        logic out_free;
    } t_status;

    localparam logic [STEP_W-1:0] STEP_LUT [0:48] = '{
        11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,
        11'd31,   11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,
        11'd60,   11'd66,   11'd73,   11'd80,   11'd88,   11'd97,   11'd107,
        11'd118,  11'd130,  11'd143,  11'd157,  11'd173,  11'd190,  11'd209,
        11'd230,  11'd253,  11'd279,  11'd307,  11'd337,  11'd371,  11'd408,
        11'd449,  11'd494,  11'd544,  11'd598,  11'd658,  11'd724,  11'd796,
        11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552
    };

    function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        s = '0;
        if (idx <= IDX_MAX) begin
            s = STEP_LUT[idx];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/adpcm_stream_player.sv
// Channel    Dir  Handshake                    Payload
// s_axis     in   i_s_axis_tvalid/o_s_axis_tready  tdata: address, length, data; tuser: opcode
// m_axis     out  o_m_axis_tvalid/i_m_axis_tready  tdata: sample; tuser: active
// cfg        in   i_cfg_valid/o_cfg_ready          phase increment, always ready
//
// A microcoded sequencer runs one item at a time; the next request is taken once
// the program returns to dispatch. A playing tick adds the phase increment, then
// per decoded nibble steps the phase, fetches, forms the difference, updates and
// tests the loop; reaching the stream end stops playback before the emit step.
// A full output register holds the sequencer at its emit step; other items are not
// held. Reset is synchronous; the sample memory has no reset and needs no clearing.
`default_nettype none

module adpcm_stream_player
    import asp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // address[15:0], length[32:16], data[40:33]
    input  wire logic [2:0]  i_s_axis_tuser,   // opcode[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // sample[15:0]
    output logic             o_m_axis_tuser,   // active[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [17:0] i_cfg_data
);

    t_ctrl   w_ctrl;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    asp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_opcode   (i_s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    asp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_address   (i_s_axis_tdata[15:0]),
        .i_length    (i_s_axis_tdata[32:16]),
        .i_data      (i_s_axis_tdata[40:33]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_sample    (o_m_axis_tdata),
        .o_active    (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

### rtl/asp_sequencer.sv
`default_nettype none

module asp_sequencer
    import asp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire t_status             i_status,
    output logic                     o_in_ready,
    output t_ctrl                    o_ctrl
);

    // Microcode addresses
    localparam logic [UPC_W-1:0] UA_DISPATCH  = 5'd0;
    localparam logic [UPC_W-1:0] UA_LOAD      = 5'd1;
    localparam logic [UPC_W-1:0] UA_CTRL      = 5'd2;
    localparam logic [UPC_W-1:0] UA_NIBBLE    = 5'd3;
    localparam logic [UPC_W-1:0] UA_NIB_APPLY = 5'd4;
    localparam logic [UPC_W-1:0] UA_START     = 5'd5;
    localparam logic [UPC_W-1:0] UA_TICK      = 5'd6;
    localparam logic [UPC_W-1:0] UA_PH_ADD    = 5'd7;
    localparam logic [UPC_W-1:0] UA_LOOP      = 5'd8;
    localparam logic [UPC_W-1:0] UA_PH_SUB    = 5'd9;
    localparam logic [UPC_W-1:0] UA_READ      = 5'd10;
    localparam logic [UPC_W-1:0] UA_DIFF      = 5'd11;
    localparam logic [UPC_W-1:0] UA_APPLY     = 5'd12;
    localparam logic [UPC_W-1:0] UA_STOP      = 5'd13;
    localparam logic [UPC_W-1:0] UA_EMIT_ACT  = 5'd14;
    localparam logic [UPC_W-1:0] UA_EMIT_WAIT = 5'd15;
    localparam logic [UPC_W-1:0] UA_EMIT_IDLE = 5'd16;
    localparam logic [UPC_W-1:0] UA_IDLE_WAIT = 5'd17;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w_word;
    logic             w_accept;
    logic [UPC_W-1:0] w_entry;

    // Control store
    always_comb begin
        case (r_upc)
            UA_DISPATCH:  w_word = '{DP_NOP,       C_DISPATCH,  UA_DISPATCH};
            UA_LOAD:      w_word = '{DP_LOAD,      C_ALWAYS,    UA_DISPATCH};
            UA_CTRL:      w_word = '{DP_CTRL,      C_ALWAYS,    UA_DISPATCH};
            UA_NIBBLE:    w_word = '{DP_DIFF_DATA, C_NEXT,      UA_DISPATCH};
            UA_NIB_APPLY: w_word = '{DP_APPLY,     C_ALWAYS,    UA_DISPATCH};
            UA_START:     w_word = '{DP_START,     C_ALWAYS,    UA_DISPATCH};
            UA_TICK:      w_word = '{DP_NOP,       C_NO_GO,     UA_EMIT_IDLE};
            UA_PH_ADD:    w_word = '{DP_PHASE_ADD, C_NEXT,      UA_DISPATCH};
            UA_LOOP:      w_word = '{DP_NOP,       C_PHASE_LOW, UA_EMIT_ACT};
            UA_PH_SUB:    w_word = '{DP_PHASE_SUB, C_AT_END,    UA_STOP};
            UA_READ:      w_word = '{DP_MEM_READ,  C_NEXT,      UA_DISPATCH};
            UA_DIFF:      w_word = '{DP_DIFF_MEM,  C_NEXT,      UA_DISPATCH};
            UA_APPLY:     w_word = '{DP_APPLY,     C_ALWAYS,    UA_LOOP};
            UA_STOP:      w_word = '{DP_STOP,      C_NEXT,      UA_DISPATCH};
            UA_EMIT_ACT:  w_word = '{DP_EMIT_ACT,  C_OUT_FREE,  UA_DISPATCH};
            UA_EMIT_WAIT: w_word = '{DP_NOP,       C_ALWAYS,    UA_EMIT_ACT};
            UA_EMIT_IDLE: w_word = '{DP_EMIT_IDLE, C_OUT_FREE,  UA_DISPATCH};
            UA_IDLE_WAIT: w_word = '{DP_NOP,       C_ALWAYS,    UA_EMIT_IDLE};
            default:      w_word = '{DP_NOP,       C_ALWAYS,    UA_DISPATCH};
        endcase
    end

    // Entry point per item kind; unused kinds are dropped
    always_comb begin
        case (i_opcode)
            OP_LOAD:   w_entry = UA_LOAD;
            OP_CTRL:   w_entry = UA_CTRL;
            OP_NIBBLE: w_entry = UA_NIBBLE;
            OP_START:  w_entry = UA_START;
            OP_TICK:   w_entry = UA_TICK;
            default:   w_entry = UA_DISPATCH;
        endcase
    end

    assign o_in_ready = (r_upc == UA_DISPATCH);
    assign w_accept   = o_in_ready && i_in_valid;

    // Branch resolution
    always_comb begin
        case (w_word.cond)
            C_NEXT:      n_upc = r_upc + UPC_W'(1);
            C_ALWAYS:    n_upc = w_word.target;
            C_DISPATCH:  n_upc = w_accept ? w_entry : UA_DISPATCH;
            C_NO_GO:     n_upc = i_status.no_go     ? w_word.target : r_upc + UPC_W'(1);
            C_PHASE_LOW: n_upc = i_status.phase_low ? w_word.target : r_upc + UPC_W'(1);
            C_AT_END:    n_upc = i_status.at_end    ? w_word.target : r_upc + UPC_W'(1);
            C_OUT_FREE:  n_upc = i_status.out_free  ? w_word.target : r_upc + UPC_W'(1);
            default:     n_upc = UA_DISPATCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_DISPATCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.accept = w_accept;
    assign o_ctrl.op     = w_word.op;

endmodule

`default_nettype wire

### rtl/asp_datapath.sv
`default_nettype none

module asp_datapath
    import asp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl                 i_ctrl,
    input  wire logic [ADDR_W-1:0]     i_address,
    input  wire logic [LEN_W-1:0]      i_length,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic [INC_W-1:0]      i_cfg_data,
    input  wire logic                  i_out_ready,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [SAMPLE_W-1:0]        o_sample,
    output logic                       o_active
);

    logic [DATA_W-1:0] r_mem [0:MEM_DEPTH-1];

    logic [ADDR_W-1:0]  r_addr;
    logic [LEN_W-1:0]   r_len;
    logic [DATA_W-1:0]  r_data;

    logic [INC_W-1:0]   r_inc;
    logic [POS_W-1:0]   r_filled;
    logic [PRED_W-1:0]  r_pred;
    logic [IDX_W-1:0]   r_idx;
    logic               r_low_next;
    logic [POS_W-1:0]   r_read;
    logic [POS_W-1:0]   r_end;
    logic [PHASE_W-1:0] r_phase;
    logic               r_playing;

    logic [DATA_W-1:0]  r_mem_q;
    logic               r_sel_low;
    logic [3:0]         r_nib;
    logic [DIFF_W-1:0]  r_diff;

    logic               r_out_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic               r_active;

    logic               w_out_free;
    logic [3:0]         w_nib;
    logic [STEP_W-1:0]  w_step;
    logic [DIFF_W-1:0]  n_diff;
    logic [13:0]        w_pext;
    logic [13:0]        w_dext;
    logic [13:0]        w_sum;
    logic [PRED_W-1:0]  n_pred;
    logic [6:0]         w_move;
    logic [6:0]         w_idx_sum;
    logic [IDX_W-1:0]   n_idx;
    logic [POS_W:0]     w_stop;
    logic [POS_W-1:0]   n_end;
    logic [POS_W-1:0]   w_load_top;
    logic [SAMPLE_W-1:0] w_pred16;
    logic [SAMPLE_W-1:0] w_gain;

    // Status for the sequencer
    assign w_out_free          = !r_out_valid || i_out_ready;
    assign o_status.no_go      = !(r_playing && (r_filled != '0) && (r_end > r_read));
    assign o_status.phase_low  = (r_phase[PHASE_W-1:16] == '0);
    assign o_status.at_end     = (r_read >= r_end);
    assign o_status.out_free   = w_out_free;

    // Nibble source: the item's data or the selected half of the fetched byte
    always_comb begin
        if (i_ctrl.op == DP_DIFF_DATA) begin
            w_nib = r_data[3:0];
        end else begin
            w_nib = r_sel_low ? r_mem_q[3:0] : r_mem_q[7:4];
        end
    end

    // Difference magnitude from step size and nibble bits 0..2
    assign w_step = step_lookup(r_idx);
    always_comb begin
        n_diff = DIFF_W'(w_step >> 3);
        if (w_nib[0]) n_diff = n_diff + DIFF_W'(w_step >> 2);
        if (w_nib[1]) n_diff = n_diff + DIFF_W'(w_step >> 1);
        if (w_nib[2]) n_diff = n_diff + DIFF_W'(w_step);
    end

    // Predictor update with saturation
    assign w_pext = {{2{r_pred[PRED_W-1]}}, r_pred};
    assign w_dext = {2'b00, r_diff};
    assign w_sum  = r_nib[3] ? (w_pext - w_dext) : (w_pext + w_dext);
    always_comb begin
        if ($signed(w_sum) > $signed(14'sd2047)) begin
            n_pred = PRED_HI;
        end else if ($signed(w_sum) < $signed(-14'sd2048)) begin
            n_pred = PRED_LO;
        end else begin
            n_pred = w_sum[PRED_W-1:0];
        end
    end

    // Step index update: -1 for small codes, 2/4/6/8 for large
    assign w_move    = r_nib[2] ? ({4'b0000, r_nib[1:0], 1'b0} + 7'd2) : 7'h7F;
    assign w_idx_sum = {1'b0, r_idx} + w_move;
    always_comb begin
        if (w_idx_sum[6]) begin
            n_idx = '0;
        end else if (w_idx_sum[5:0] > IDX_MAX) begin
            n_idx = IDX_MAX;
        end else begin
            n_idx = w_idx_sum[5:0];
        end
    end

    // Stream end, clamped to the filled part of memory
    assign w_stop = {2'b00, r_addr} + {1'b0, r_len};
    assign n_end  = (w_stop > {1'b0, r_filled}) ? r_filled : w_stop[POS_W-1:0];

    assign w_load_top = {1'b0, r_addr} + POS_W'(1);

    // Output gain of ten as 8x + 2x
    assign w_pred16 = {{(SAMPLE_W-PRED_W){r_pred[PRED_W-1]}}, r_pred};
    assign w_gain   = (w_pred16 << 3) + (w_pred16 << 1);

    // Sample memory: write on load, registered read during playback
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == DP_LOAD) begin
            r_mem[r_addr[MEM_AW-1:0]] <= r_data;
        end
        if (i_ctrl.op == DP_MEM_READ) begin
            r_mem_q <= r_mem[r_read[MEM_AW-1:0]];
        end
    end

    // Item capture and decode scratch
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_addr <= i_address;
            r_len  <= i_length;
            r_data <= i_data;
        end
        if (i_ctrl.op == DP_MEM_READ) begin
            r_sel_low <= r_low_next;
        end
        if (i_ctrl.op == DP_DIFF_DATA || i_ctrl.op == DP_DIFF_MEM) begin
            r_nib  <= w_nib;
            r_diff <= n_diff;
        end
    end

    // Decoder and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc      <= DEFAULT_INC;
            r_filled   <= '0;
            r_pred     <= '0;
            r_idx      <= '0;
            r_low_next <= 1'b0;
            r_read     <= '0;
            r_end      <= '0;
            r_phase    <= '0;
            r_playing  <= 1'b0;
        end else begin
            case (i_ctrl.op)
                DP_LOAD: begin
                    if (w_load_top > r_filled) begin
                        r_filled <= w_load_top;
                    end
                end
                DP_CTRL: begin
                    if (r_data[1]) begin
                        r_playing <= 1'b0;
                    end else begin
                        r_pred     <= '0;
                        r_idx      <= '0;
                        r_low_next <= 1'b0;
                        r_phase    <= '0;
                        r_playing  <= 1'b1;
                    end
                end
                DP_START: begin
                    if (r_filled != '0) begin
                        r_read     <= {1'b0, r_addr};
                        r_end      <= n_end;
                        r_pred     <= '0;
                        r_idx      <= '0;
                        r_low_next <= 1'b0;
                        r_phase    <= '0;
                        r_playing  <= 1'b1;
                        if (r_inc == '0) begin
                            r_inc <= DEFAULT_INC;
                        end
                    end
                end
                DP_APPLY: begin
                    r_pred    <= n_pred;
                    r_idx     <= n_idx;
                    r_playing <= 1'b1;
                end
                DP_PHASE_ADD: begin
                    r_phase <= r_phase + {1'b0, r_inc};
                end
                DP_PHASE_SUB: begin
                    r_phase[PHASE_W-1:16] <= r_phase[PHASE_W-1:16] - 3'd1;
                end
                DP_MEM_READ: begin
                    r_low_next <= !r_low_next;
                    if (r_low_next) begin
                        r_read <= r_read + POS_W'(1);
                    end
                end
                DP_STOP: begin
                    r_playing <= 1'b0;
                end
                default: begin
                end
            endcase
            // Configuration is for the user to send only while the sequencer is idle; the block does not enforce it
            if (i_cfg_valid) begin
                r_inc <= i_cfg_data;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctrl.op == DP_EMIT_ACT || i_ctrl.op == DP_EMIT_IDLE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (i_ctrl.op == DP_EMIT_ACT) begin
                r_sample <= w_gain;
                r_active <= 1'b1;
            end else if (i_ctrl.op == DP_EMIT_IDLE) begin
                r_sample <= '0;
                r_active <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_active    = r_active;

endmodule

`default_nettype wire

### rtl/asp_checker.sv
`default_nettype none

module asp_checker
    import asp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic [2:0]  i_s_tuser,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] i_m_tdata,
    input wire logic        i_m_tuser
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result dropped before it was taken");

    // An idle tick carries a zero sample
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == 16'h0000)
        else $error("idle result with nonzero sample");

    // Active samples stay within ten times the 12-bit predictor range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |->
            $signed(i_m_tdata) >= -16'sd20480 && $signed(i_m_tdata) <= 16'sd20470)
        else $error("sample out of range");

    // A known item leaves the sequencer busy in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && i_s_tuser <= OP_TICK |=> !i_s_tready)
        else $error("request taken while previous one still running");

endmodule

bind adpcm_stream_player asp_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tuser  (i_s_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire
